// ===== rtl/core/irqd_pkg.sv =====
`timescale 1ns / 1ps

package irqd_pkg;

    // Default wire count and field widths
    localparam int NUM_WIRES_DEF = 64;
    localparam int VEC_W         = 8;
    localparam int WIRE_W        = 7;
    localparam int CHOSEN_W      = 6;

    // The priority scanner looks at one group of pending lines per cycle
    localparam int GRP_W         = 8;
    localparam int GRP_IDX_W     = 3;

    // APB register port
    localparam int APB_AW        = 3;
    localparam int APB_DW        = 32;

    // Register index, taken from paddr[2]
    localparam logic REG_UNKNOWN_VEC = 1'b0;

    typedef enum logic [1:0] {
        ACT_REG   = 2'd0,
        ACT_EN    = 2'd1,
        ACT_DIS   = 2'd2,
        ACT_QUERY = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_LOAD,
        S_PUSH
    } t_state;

    // Sequencer to vector table
    typedef struct packed {
        logic                wr;
        logic                rd;
        logic [CHOSEN_W-1:0] addr;
        logic [VEC_W-1:0]    data;
    } t_vt_req;

    // Vector table read response (registered)
    typedef struct packed {
        logic             flag;
        logic [VEC_W-1:0] data;
    } t_vt_rsp;

    // One result item
    typedef struct packed {
        logic [VEC_W-1:0]    vec;
        logic [CHOSEN_W-1:0] chosen;
        logic                found;
        logic                error;
    } t_result;

endpackage

// ===== rtl/core/irq_wire_to_vector_dispatch.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake           Payload
// ------    ---------  ------------------  ---------------------------------------------
// request   in         i_valid / o_stall   i_action, i_wire_req, i_vector, i_pending
// result    out        o_valid / i_stall   o_result_vector, o_chosen_wire, o_found, o_error
// config    in         APB psel/penable    paddr, pwdata, prdata, pready (always high)
//
// Register, enable and disable are accepted, then handed off to the output register.
// A query runs the 8-line priority scanner, which walks one group per cycle over
// NGRP = ceil(NUM_WIRES / 8) groups; on a hit the single-port vector table then takes
// one registered read, and with no hit the result is unknown_vector.
// Reset is synchronous, active low; it clears enables, bound flags and unknown_vector.
// o_stall is high while an item is in work or its result cannot enter the output register.
module irq_wire_to_vector_dispatch import irqd_pkg::*; #(
    parameter int NUM_WIRES = NUM_WIRES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // request channel
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [1:0]          i_action,
    input  logic [WIRE_W-1:0]   i_wire_req,
    input  logic [VEC_W-1:0]    i_vector,
    input  logic [63:0]         i_pending,
    // result channel
    output logic                o_valid,
    input  logic                i_stall,
    output logic [VEC_W-1:0]    o_result_vector,
    output logic [CHOSEN_W-1:0] o_chosen_wire,
    output logic                o_found,
    output logic                o_error,
    // config port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    localparam int AW   = $clog2(NUM_WIRES);
    localparam int NGRP = (NUM_WIRES + GRP_W - 1) / GRP_W;
    localparam int GW   = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam int HP   = NGRP * GRP_W;
    localparam int SW   = GW + GRP_IDX_W;

    t_state               r_state, n_state;
    t_result              r_res, n_res;
    t_result              r_out;
    logic                 r_ovalid;
    logic [GW-1:0]        r_grp, n_grp;
    logic [HP-1:0]        r_hits, n_hits;
    logic [NUM_WIRES-1:0] r_en, n_en;
    logic [VEC_W-1:0]     r_unknown;

    t_vt_req              vt_req;
    t_vt_rsp              vt_rsp;
    t_action              act;
    logic                 wire_ok;
    logic [AW-1:0]        widx;
    logic                 scan_hit;
    logic [GRP_IDX_W-1:0] scan_idx;
    logic [SW-1:0]        sel;
    logic                 out_free;
    logic                 out_load;
    logic                 cfg_wr;

    assign act      = t_action'(i_action);
    assign wire_ok  = (i_wire_req < WIRE_W'(NUM_WIRES));
    assign widx     = i_wire_req[AW-1:0];
    assign sel      = {r_grp, scan_idx};
    assign out_free = !r_ovalid || !i_stall;
    assign out_load = (r_state == S_PUSH) && out_free;
    assign o_stall  = (r_state != S_IDLE);

    // shared group scanner
    irqd_scan u_scan (
        .i_bits (r_hits[GRP_W-1:0]),
        .o_hit  (scan_hit),
        .o_idx  (scan_idx)
    );

    // vector table
    irqd_vtab #(
        .NUM_WIRES (NUM_WIRES)
    ) u_vtab (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (vt_req),
        .o_rsp   (vt_rsp)
    );

    // sequencer: next state and datapath control
    always_comb begin
        n_state = r_state;
        n_res   = r_res;
        n_grp   = r_grp;
        n_hits  = r_hits;
        n_en    = r_en;
        vt_req  = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_res = '0;
                    if (act == ACT_QUERY) begin
                        n_hits  = HP'(i_pending[NUM_WIRES-1:0] & r_en);
                        n_grp   = '0;
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_PUSH;
                        if (!wire_ok) begin
                            n_res.error = 1'b1;
                        end else begin
                            case (act)
                                ACT_REG: begin
                                    vt_req.wr   = 1'b1;
                                    vt_req.addr = CHOSEN_W'(widx);
                                    vt_req.data = i_vector;
                                    n_res.vec   = i_vector;
                                end
                                ACT_EN:  n_en[widx] = 1'b1;
                                ACT_DIS: n_en[widx] = 1'b0;
                                default: ;
                            endcase
                        end
                    end
                end
            end
            S_SCAN: begin
                if (scan_hit) begin
                    vt_req.rd    = 1'b1;
                    vt_req.addr  = CHOSEN_W'(sel);
                    n_res.chosen = CHOSEN_W'(sel);
                    n_res.found  = 1'b1;
                    n_state      = S_LOAD;
                end else if (r_grp == GW'(NGRP - 1)) begin
                    n_res.vec = r_unknown;
                    n_state   = S_PUSH;
                end else begin
                    n_grp  = r_grp + 1'b1;
                    n_hits = r_hits >> GRP_W;
                end
            end
            S_LOAD: begin
                n_res.vec = vt_rsp.flag ? vt_rsp.data : r_unknown;
                n_state   = S_PUSH;
            end
            S_PUSH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_en    <= '0;
        end else begin
            r_state <= n_state;
            r_en    <= n_en;
        end
    end

    // work registers
    always_ff @(posedge i_clk) begin
        r_res  <= n_res;
        r_grp  <= n_grp;
        r_hits <= n_hits;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_load) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= r_res;
        end
    end

    assign o_valid         = r_ovalid;
    assign o_result_vector = r_out.vec;
    assign o_chosen_wire   = r_out.chosen;
    assign o_found         = r_out.found;
    assign o_error         = r_out.error;

    // config register
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_UNKNOWN_VEC) ? APB_DW'(r_unknown) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unknown <= '0;
        end else if (cfg_wr && (paddr[2] == REG_UNKNOWN_VEC)) begin
            r_unknown <= pwdata[VEC_W-1:0];
        end
    end

    // a query transfer always starts the scan
    a_query_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_valid && act == ACT_QUERY) |=> (r_state == S_SCAN))
        else $error("query did not start scan");

    // the group counter stays inside the scanned range
    a_grp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_grp <= GW'(NGRP - 1)))
        else $error("scan group out of range");

    // a found wire is always a real wire
    a_found_wire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_out.found) |-> ({1'b0, r_out.chosen} < WIRE_W'(NUM_WIRES)))
        else $error("chosen wire beyond wire count");

    // an error result carries nothing else
    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_out.error) |-> (!r_out.found && r_out.vec == '0 && r_out.chosen == '0))
        else $error("error result with payload");

    // table read only after a scanner hit, and its data used next cycle
    a_load_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |-> ($past(r_state) == S_SCAN && $past(scan_hit)))
        else $error("load without scanner hit");

endmodule

// ===== rtl/core/irqd_scan.sv =====
`timescale 1ns / 1ps

// Lowest-set-bit finder over one group of pending lines
module irqd_scan import irqd_pkg::*; (
    input  logic [GRP_W-1:0]     i_bits,
    output logic                 o_hit,
    output logic [GRP_IDX_W-1:0] o_idx
);

    always_comb begin
        o_hit = |i_bits;
        o_idx = '0;
        // walk down so the lowest set bit wins
        for (int i = GRP_W - 1; i >= 0; i--) begin
            if (i_bits[i]) begin
                o_idx = GRP_IDX_W'(i);
            end
        end
    end

endmodule

// ===== rtl/core/irqd_vtab.sv =====
`timescale 1ns / 1ps

// Vector table: single-port memory with registered read, plus bound flags
module irqd_vtab import irqd_pkg::*; #(
    parameter int NUM_WIRES = NUM_WIRES_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_vt_req i_req,
    output t_vt_rsp o_rsp
);

    localparam int AW = $clog2(NUM_WIRES);

    logic [VEC_W-1:0]     r_mem [NUM_WIRES];
    logic [NUM_WIRES-1:0] r_flags;
    logic [VEC_W-1:0]     r_rd_data;
    logic                 r_rd_flag;
    logic [AW-1:0]        addr;

    assign addr = i_req.addr[AW-1:0];

    // memory write and registered read
    always_ff @(posedge i_clk) begin
        if (i_req.wr) begin
            r_mem[addr] <= i_req.data;
        end
        if (i_req.rd) begin
            r_rd_data <= r_mem[addr];
            r_rd_flag <= r_flags[addr];
        end
    end

    // bound flags, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else if (i_req.wr) begin
            r_flags[addr] <= 1'b1;
        end
    end

    assign o_rsp = '{flag: r_rd_flag, data: r_rd_data};

endmodule
